FILE: rtl/core/epc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epc_pkg: shared types and constants for the epoch-seconds to calendar block
// Holds the sequencer state type, the widths of the shared compare-subtract
// unit and the month length table.
// ----------------------------------------------------------------------------
package epc_pkg;

	// Width of the shared compare-subtract unit. The widest operand is the
	// shifted remainder of the division by the day length (below 2 * 86400).
	localparam int unsigned UNIT_W = 18;

	localparam logic [UNIT_W-1:0] SECS_PER_DAY  = UNIT_W'(86400);
	localparam logic [UNIT_W-1:0] SECS_PER_HOUR = UNIT_W'(3600);
	localparam logic [UNIT_W-1:0] SECS_PER_MIN  = UNIT_W'(60);
	localparam logic [UNIT_W-1:0] DAYS_COMMON   = UNIT_W'(365);
	localparam logic [UNIT_W-1:0] DAYS_LEAP     = UNIT_W'(366);

	localparam logic [11:0] BASE_YEAR     = 12'd1970;
	localparam logic [1:0]  BASE_MOD4     = 2'd2;
	localparam logic [6:0]  BASE_MOD100   = 7'd70;
	localparam logic [8:0]  BASE_MOD400   = 9'd370;
	localparam logic [6:0]  LAST_MOD100   = 7'd99;
	localparam logic [8:0]  LAST_MOD400   = 9'd399;
	localparam logic [3:0]  MONTH_FEB     = 4'd1;
	localparam logic [3:0]  MONTH_DEC     = 4'd11;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DAYS,
		ST_YEARS,
		ST_MONTHS,
		ST_HOURS,
		ST_MINUTES
	} epc_state_t;

	// Length of a month in days; February grows by one in a leap year.
	function automatic logic [UNIT_W-1:0] month_len(input logic [3:0] mon, input logic leap);
		logic [4:0] len;
		begin
			case (mon)
				4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
				4'd3, 4'd5, 4'd8, 4'd10:                   len = 5'd30;
				MONTH_FEB:                                 len = leap ? 5'd29 : 5'd28;
				default:                                   len = 5'd31;
			endcase
			month_len = UNIT_W'(len);
		end
	endfunction

endpackage

FILE: rtl/core/epoch_seconds_to_calendar_date.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_date: seconds since 1970 to calendar fields
// Converts an unsigned 32-bit seconds count into year, month, day of month,
// day of year, hour, minute and second with a small sequencer driving one
// shared compare-and-subtract unit.
// ----------------------------------------------------------------------------
// A request is taken when start is high while busy is low. The block then
// holds busy high for the whole conversion and answers with done high for
// exactly one cycle, with all result fields valid in that cycle; the receiver
// cannot stall, so the result must be captured then. A conversion runs the
// long division by the day length, one step per year from 1970 plus one, one
// step per month plus one, the hour and minute divisions and the cycle in
// which done is high; its length is set by the single compare-subtract unit
// that every step shares. A new request may be given in the cycle in which
// done is high.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_date (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] epoch_seconds,
	output logic        done,
	output logic [11:0] year,
	output logic [3:0]  month,
	output logic [4:0]  day_of_month,
	output logic [8:0]  day_of_year,
	output logic [4:0]  hour,
	output logic [5:0]  minute,
	output logic [5:0]  second
);

	import epc_pkg::*;

	epc_state_t state_q, state_d;

	// Working registers. div_q first holds the low dividend bits and collects
	// the day count as quotient bits shift in; after that it holds the days
	// still to be peeled off by the year and month steps.
	logic [15:0]       div_q;
	logic [16:0]       rem_q;
	logic [3:0]        cnt_q;
	logic [11:0]       year_q;
	logic [1:0]        mod4_q;
	logic [6:0]        mod100_q;
	logic [8:0]        mod400_q;
	logic [8:0]        yday_q;
	logic [3:0]        mon_q;
	logic [4:0]        hour_q;
	logic [5:0]        min_q;
	logic              done_q;

	logic              leap;
	logic [UNIT_W-1:0] op_a, op_b, diff;
	logic              ge;
	logic              accept;

	assign accept = start && (state_q == ST_IDLE);

	// Gregorian rule from the running residues of the year.
	assign leap = (mod4_q == 2'd0) && ((mod100_q != 7'd0) || (mod400_q == 9'd0));

	// Operand selection for the shared unit, one use per state.
	always_comb begin
		op_a = '0;
		op_b = '0;
		case (state_q)
			ST_DAYS: begin
				op_a = {rem_q, div_q[15]};
				op_b = SECS_PER_DAY;
			end
			ST_YEARS: begin
				op_a = UNIT_W'(div_q);
				op_b = leap ? DAYS_LEAP : DAYS_COMMON;
			end
			ST_MONTHS: begin
				op_a = UNIT_W'(div_q);
				op_b = month_len(mon_q, leap);
			end
			ST_HOURS: begin
				op_a = UNIT_W'(rem_q);
				op_b = SECS_PER_HOUR << cnt_q;
			end
			ST_MINUTES: begin
				op_a = UNIT_W'(rem_q);
				op_b = SECS_PER_MIN << cnt_q;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	epc_cmpsub #(
		.W(UNIT_W)
	) u_cmpsub (
		.a    (op_a),
		.b    (op_b),
		.ge   (ge),
		.diff (diff)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state. The day division runs a fixed 16 steps; the year and month
	// steps stop as soon as the remaining days no longer cover the period, the month steps at December at the latest.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_DAYS;
			end
			ST_DAYS: begin
				if (cnt_q == 4'd0) state_d = ST_YEARS;
			end
			ST_YEARS: begin
				if (!ge) state_d = ST_MONTHS;
			end
			ST_MONTHS: begin
				if (!ge || (mon_q == MONTH_DEC)) state_d = ST_HOURS;
			end
			ST_HOURS: begin
				if (cnt_q == 4'd0) state_d = ST_MINUTES;
			end
			ST_MINUTES: begin
				if (cnt_q == 4'd0) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_MINUTES) && (cnt_q == 4'd0);
		end
	end

	// Datapath registers. They only change on a request or while working, so
	// the fields stay put through the cycle in which done is high.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					// The top half is always below the day length, so it can
					// seed the remainder and only 16 quotient bits remain.
					rem_q    <= {1'b0, epoch_seconds[31:16]};
					div_q    <= epoch_seconds[15:0];
					cnt_q    <= 4'd15;
					year_q   <= BASE_YEAR;
					mod4_q   <= BASE_MOD4;
					mod100_q <= BASE_MOD100;
					mod400_q <= BASE_MOD400;
				end
			end
			ST_DAYS: begin
				rem_q <= ge ? diff[16:0] : op_a[16:0];
				div_q <= {div_q[14:0], ge};
				cnt_q <= cnt_q - 4'd1;
			end
			ST_YEARS: begin
				if (ge) begin
					div_q    <= diff[15:0];
					year_q   <= year_q + 12'd1;
					mod4_q   <= mod4_q + 2'd1;
					mod100_q <= (mod100_q == LAST_MOD100) ? 7'd0 : mod100_q + 7'd1;
					mod400_q <= (mod400_q == LAST_MOD400) ? 9'd0 : mod400_q + 9'd1;
				end else begin
					yday_q <= div_q[8:0];
					mon_q  <= 4'd0;
				end
			end
			ST_MONTHS: begin
				if (ge && (mon_q != MONTH_DEC)) begin
					div_q <= diff[15:0];
					mon_q <= mon_q + 4'd1;
				end else begin
					cnt_q  <= 4'd4;
					hour_q <= 5'd0;
				end
			end
			ST_HOURS: begin
				// Restoring division with the divisor shifted; quotient MSB first.
				if (ge) rem_q <= diff[16:0];
				hour_q <= {hour_q[3:0], ge};
				if (cnt_q == 4'd0) begin
					cnt_q <= 4'd5;
					min_q <= 6'd0;
				end else begin
					cnt_q <= cnt_q - 4'd1;
				end
			end
			ST_MINUTES: begin
				if (ge) rem_q <= diff[16:0];
				min_q <= {min_q[4:0], ge};
				if (cnt_q != 4'd0) cnt_q <= cnt_q - 4'd1;
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	assign busy         = (state_q != ST_IDLE);
	assign done         = done_q;
	assign year         = year_q;
	assign month        = mon_q;
	assign day_of_month = div_q[4:0] + 5'd1;
	assign day_of_year  = yday_q;
	assign hour         = hour_q;
	assign minute       = min_q;
	assign second       = rem_q[5:0];

endmodule

FILE: rtl/core/epc_cmpsub.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epc_cmpsub: shared compare-and-subtract unit
// Reports whether a is at least b and gives the difference a - b.
// ----------------------------------------------------------------------------
module epc_cmpsub #(
	parameter int unsigned W = 18
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic         ge,
	output logic [W-1:0] diff
);

	logic [W:0] wide_diff;

	// The borrow out of the subtraction gives the compare for free.
	assign wide_diff = {1'b0, a} - {1'b0, b};
	assign ge        = ~wide_diff[W];
	assign diff      = wide_diff[W-1:0];

endmodule

FILE: rtl/core/epc_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epc_chk: port-level checks for the calendar conversion block
// Watches the request and result ports and flags sequencing slips.
// ----------------------------------------------------------------------------
module epc_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [31:0] epoch_seconds,
	input logic        done,
	input logic [11:0] year,
	input logic [3:0]  month,
	input logic [4:0]  day_of_month,
	input logic [8:0]  day_of_year,
	input logic [4:0]  hour,
	input logic [5:0]  minute,
	input logic [5:0]  second
);

	// A taken request always starts a conversion.
	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request taken but block not busy");

	// A result only appears when the block has just finished working.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("done without a finished conversion");

	// Ending a conversion always delivers its result.
	a_busy_end_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("conversion ended without a result");

	// The delivered fields stay within their calendar ranges.
	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> month <= 4'd11 && day_of_month != 5'd0 && hour <= 5'd23
			&& minute <= 6'd59 && second <= 6'd59 && day_of_year <= 9'd365
			&& year >= 12'd1970 && year <= 12'd2106)
		else $error("result field out of range");

endmodule

bind epoch_seconds_to_calendar_date epc_chk u_epc_chk (.*);
